@@ sv/cib_pkg.sv @@
// Shared constants, types and floating-point helpers for the cubic inverse block.
package cib_pkg;

   localparam int DBL_W             = 64;
   localparam int CODE_W            = 32;
   localparam int CSR_IDX_W         = 2;
   localparam int MAX_STEPS_DEFAULT = 64;

   localparam logic [CSR_IDX_W-1:0] CSR_COEF_CUBIC  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_SQUARE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_LINEAR = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_OFFSET = 2'd3;

   typedef logic [1:0] fop_type;
   localparam fop_type FOP_MUL = 2'd0;
   localparam fop_type FOP_ADD = 2'd1;
   localparam fop_type FOP_CVT = 2'd2;

   typedef struct packed {
      logic             start;
      fop_type          op;
      logic [DBL_W-1:0] a;
      logic [DBL_W-1:0] b;
   } fpu_req_type;

   typedef struct packed {
      logic             done;
      logic [DBL_W-1:0] result;
   } fpu_rsp_type;

   function automatic logic fp_is_nan(input logic [DBL_W-1:0] v);
      return (&v[62:52]) && (|v[51:0]);
   endfunction

   // IEEE less-than: false on NaN, signed zeros compare equal.
   function automatic logic fp_lt(input logic [DBL_W-1:0] a, input logic [DBL_W-1:0] b);
      logic r;
      if (fp_is_nan(a) || fp_is_nan(b)) begin
         r = 1'b0;
      end else if (a[62:0] == 63'd0 && b[62:0] == 63'd0) begin
         r = 1'b0;
      end else if (a[63] != b[63]) begin
         r = a[63];
      end else if (!a[63]) begin
         r = a[62:0] < b[62:0];
      end else begin
         r = a[62:0] > b[62:0];
      end
      return r;
   endfunction

   function automatic logic fp_le(input logic [DBL_W-1:0] a, input logic [DBL_W-1:0] b);
      logic eq;
      eq = !fp_is_nan(a) && !fp_is_nan(b) &&
           ((a == b) || (a[62:0] == 63'd0 && b[62:0] == 63'd0));
      return eq || fp_lt(a, b);
   endfunction

   // Exact midpoint of two codes, a half rounded away from zero.
   function automatic logic signed [CODE_W-1:0] mid_round(input logic signed [CODE_W-1:0] l,
                                                          input logic signed [CODE_W-1:0] r);
      logic signed [CODE_W:0] s;
      logic signed [CODE_W:0] t;
      s = {l[CODE_W-1], l} + {r[CODE_W-1], r};
      if (!s[0]) begin
         t = s;
      end else if (!s[CODE_W]) begin
         t = s + (CODE_W+1)'(1);
      end else begin
         t = s - (CODE_W+1)'(1);
      end
      t = t >>> 1;
      return t[CODE_W-1:0];
   endfunction

endpackage

@@ sv/cib_if.sv @@
// Request and response channel interfaces of the cubic inverse block.
interface cib_req_if;
   logic                       valid;
   logic                       ready;
   logic [cib_pkg::DBL_W-1:0]  target_pressure;
   modport source (output valid, output target_pressure, input ready);
   modport sink   (input valid, input target_pressure, output ready);
endinterface

interface cib_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [cib_pkg::CODE_W-1:0] conv_code;
   logic                              found;
   modport source (output valid, output conv_code, output found, input ready);
   modport sink   (input valid, input conv_code, input found, output ready);
endinterface

@@ sv/cib_fpu.sv @@
// Multi-cycle binary64 unit: multiply, add and 32-bit integer convert, round to nearest even.
module cib_fpu (
   input  logic                 clock,
   input  logic                 reset,
   input  cib_pkg::fpu_req_type fpu_req,
   output cib_pkg::fpu_rsp_type fpu_rsp
);
   import cib_pkg::*;

   localparam int SW = 128;
   localparam int EW = 14;
   localparam logic [DBL_W-1:0] QNAN = 64'h7FF8_0000_0000_0000;

   localparam logic [2:0] F_IDLE   = 3'd0;
   localparam logic [2:0] F_MUL    = 3'd1;
   localparam logic [2:0] F_ALIGN  = 3'd2;
   localparam logic [2:0] F_ADD    = 3'd3;
   localparam logic [2:0] F_NORM   = 3'd4;
   localparam logic [2:0] F_POST   = 3'd5;
   localparam logic [2:0] F_DENORM = 3'd6;
   localparam logic [2:0] F_ROUND  = 3'd7;

   logic [2:0]           state_ff, state_in;
   logic [2:0]           cnt_ff, cnt_in;
   logic                 done_ff, done_in;
   logic [DBL_W-1:0]     res_ff, res_in;
   logic                 sign_ff, sign_in;
   logic signed [EW-1:0] exp_ff, exp_in;
   logic [SW-1:0]        s_ff, s_in;
   logic [SW-1:0]        sa_ff, sa_in;
   logic                 st_ff, st_in;
   logic                 sub_ff, sub_in;
   logic                 subn_ff, subn_in;
   logic [6:0]           shamt_ff, shamt_in;
   logic [52:0]          ma_ff, ma_in;
   logic [52:0]          mb_ff, mb_in;

   logic [10:0]          a_ef, b_ef;
   logic [52:0]          a_m, b_m, big_m, sml_m;
   logic signed [EW-1:0] a_e, b_e, big_e, sml_e, ediff, biased, dd;
   logic                 a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, b_big;
   logic [31:0]          cvt_mag;
   logic [7:0]           amt;
   logic [SW:0]          rsh, lsh;
   logic [26:0]          pp_x, pp_y;
   logic [53:0]          pp;
   logic [SW-1:0]        addend;
   logic                 rnd_inc;
   logic [62:0]          rnd_mag;

   function automatic logic [SW:0] rsh_step(input logic [SW-1:0] v, input logic [7:0] n);
      logic [SW-1:0] mask;
      mask = (SW'(1) << n) - SW'(1);
      return {|(v & mask), v >> n};
   endfunction

   function automatic logic [SW:0] lsh_step(input logic [SW-1:0] v, input logic [7:0] n);
      logic [SW-1:0] mask;
      mask = ~({SW{1'b1}} >> n);
      return {(v & mask) == '0, v << n};
   endfunction

   always_comb begin
      a_ef   = fpu_req.a[62:52];
      b_ef   = fpu_req.b[62:52];
      a_m    = {a_ef != 11'd0, fpu_req.a[51:0]};
      b_m    = {b_ef != 11'd0, fpu_req.b[51:0]};
      a_e    = (a_ef == 11'd0) ? -14'sd1022 : $signed({3'b000, a_ef}) - 14'sd1023;
      b_e    = (b_ef == 11'd0) ? -14'sd1022 : $signed({3'b000, b_ef}) - 14'sd1023;
      a_nan  = fp_is_nan(fpu_req.a);
      b_nan  = fp_is_nan(fpu_req.b);
      a_inf  = (&a_ef) && (fpu_req.a[51:0] == 52'd0);
      b_inf  = (&b_ef) && (fpu_req.b[51:0] == 52'd0);
      a_zero = fpu_req.a[62:0] == 63'd0;
      b_zero = fpu_req.b[62:0] == 63'd0;
      b_big  = (b_e > a_e) || (b_e == a_e && b_m > a_m);
      big_m  = b_big ? b_m : a_m;
      sml_m  = b_big ? a_m : b_m;
      big_e  = b_big ? b_e : a_e;
      sml_e  = b_big ? a_e : b_e;
      ediff  = big_e - sml_e;
      cvt_mag = fpu_req.a[31] ? (~fpu_req.a[31:0] + 32'd1) : fpu_req.a[31:0];

      amt    = 8'd64 >> cnt_ff;
      rsh    = rsh_step(s_ff, amt);
      lsh    = lsh_step(s_ff, amt);
      biased = exp_ff + 14'sd1023;
      dd     = 14'sd1 - biased;

      // One 27x27 partial product per cycle, placed so the product's top bit is bit 127.
      case (cnt_ff[1:0])
         2'd0:    begin pp_x = ma_ff[26:0];          pp_y = mb_ff[26:0];          end
         2'd1:    begin pp_x = ma_ff[26:0];          pp_y = {1'b0, mb_ff[52:27]}; end
         2'd2:    begin pp_x = {1'b0, ma_ff[52:27]}; pp_y = mb_ff[26:0];          end
         default: begin pp_x = {1'b0, ma_ff[52:27]}; pp_y = {1'b0, mb_ff[52:27]}; end
      endcase
      pp = pp_x * pp_y;
      case (cnt_ff[1:0])
         2'd0:    addend = SW'(pp) << 22;
         2'd3:    addend = SW'(pp) << 76;
         default: addend = SW'(pp) << 49;
      endcase

      rnd_inc = s_ff[74] && ((|s_ff[73:0]) || st_ff || s_ff[75]);
      rnd_mag = {(subn_ff ? 11'd0 : exp_ff[10:0]), s_ff[126:75]} + 63'(rnd_inc);

      state_in = state_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      res_in   = res_ff;
      sign_in  = sign_ff;
      exp_in   = exp_ff;
      s_in     = s_ff;
      sa_in    = sa_ff;
      st_in    = st_ff;
      sub_in   = sub_ff;
      subn_in  = subn_ff;
      shamt_in = shamt_ff;
      ma_in    = ma_ff;
      mb_in    = mb_ff;

      unique case (state_ff)
         F_IDLE: begin
            if (fpu_req.start) begin
               st_in  = 1'b0;
               cnt_in = 3'd0;
               case (fpu_req.op)
                  FOP_MUL: begin
                     if (a_nan || b_nan || (a_inf && b_zero) || (a_zero && b_inf)) begin
                        res_in = QNAN;  done_in = 1'b1;
                     end else if (a_inf || b_inf) begin
                        res_in  = {fpu_req.a[63] ^ fpu_req.b[63], 11'h7FF, 52'd0};
                        done_in = 1'b1;
                     end else if (a_zero || b_zero) begin
                        res_in  = {fpu_req.a[63] ^ fpu_req.b[63], 63'd0};
                        done_in = 1'b1;
                     end else begin
                        ma_in    = a_m;
                        mb_in    = b_m;
                        sign_in  = fpu_req.a[63] ^ fpu_req.b[63];
                        exp_in   = a_e + b_e + 14'sd1;
                        s_in     = '0;
                        state_in = F_MUL;
                     end
                  end
                  FOP_ADD: begin
                     if (a_nan || b_nan || (a_inf && b_inf && fpu_req.a[63] != fpu_req.b[63]))
                     begin
                        res_in = QNAN;  done_in = 1'b1;
                     end else if (a_zero && b_zero) begin
                        // Two zeros only sum to minus zero when both are negative.
                        res_in  = {fpu_req.a[63] & fpu_req.b[63], 63'd0};
                        done_in = 1'b1;
                     end else if (a_inf || b_zero) begin
                        res_in = fpu_req.a;  done_in = 1'b1;
                     end else if (b_inf || a_zero) begin
                        res_in = fpu_req.b;  done_in = 1'b1;
                     end else begin
                        sa_in    = SW'(big_m) << 74;
                        sign_in  = b_big ? fpu_req.b[63] : fpu_req.a[63];
                        sub_in   = fpu_req.a[63] != fpu_req.b[63];
                        exp_in   = big_e + 14'sd1;
                        shamt_in = ediff[6:0];
                        if (ediff > 14'sd127) begin
                           s_in     = '0;
                           st_in    = 1'b1;
                           state_in = F_ADD;
                        end else begin
                           s_in     = SW'(sml_m) << 74;
                           state_in = F_ALIGN;
                        end
                     end
                  end
                  FOP_CVT: begin
                     if (fpu_req.a[31:0] == 32'd0) begin
                        res_in = '0;  done_in = 1'b1;
                     end else begin
                        s_in     = {cvt_mag, 96'd0};
                        sign_in  = fpu_req.a[31];
                        exp_in   = 14'sd31;
                        state_in = F_NORM;
                     end
                  end
                  default: begin
                     res_in = QNAN;  done_in = 1'b1;
                  end
               endcase
            end
         end
         F_MUL: begin
            s_in   = s_ff + addend;
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd3) begin
               cnt_in   = 3'd0;
               state_in = F_NORM;
            end
         end
         F_ALIGN, F_DENORM: begin
            if (shamt_ff[3'd6 - cnt_ff]) begin
               s_in  = rsh[SW-1:0];
               st_in = st_ff | rsh[SW];
            end
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd6) begin
               cnt_in   = 3'd0;
               state_in = (state_ff == F_ALIGN) ? F_ADD : F_ROUND;
            end
         end
         F_ADD: begin
            // Bits lost in alignment make a difference fall just short of the exact one.
            s_in     = sub_ff ? (sa_ff - s_ff - SW'(st_ff)) : (sa_ff + s_ff);
            state_in = F_NORM;
         end
         F_NORM: begin
            if (cnt_ff == 3'd0 && s_ff == '0) begin
               res_in   = '0;
               done_in  = 1'b1;
               state_in = F_IDLE;
            end else begin
               if (lsh[SW]) begin
                  s_in   = lsh[SW-1:0];
                  exp_in = exp_ff - $signed(EW'(amt));
               end
               cnt_in = cnt_ff + 3'd1;
               if (cnt_ff == 3'd6) begin
                  cnt_in   = 3'd0;
                  state_in = F_POST;
               end
            end
         end
         F_POST: begin
            exp_in = biased;
            if (biased >= 14'sd2047) begin
               res_in   = {sign_ff, 11'h7FF, 52'd0};
               done_in  = 1'b1;
               state_in = F_IDLE;
            end else if (biased < 14'sd1) begin
               subn_in = 1'b1;
               if (dd > 14'sd127) begin
                  st_in    = st_ff | (|s_ff);
                  s_in     = '0;
                  state_in = F_ROUND;
               end else begin
                  shamt_in = dd[6:0];
                  cnt_in   = 3'd0;
                  state_in = F_DENORM;
               end
            end else begin
               subn_in  = 1'b0;
               state_in = F_ROUND;
            end
         end
         F_ROUND: begin
            res_in   = {sign_ff, rnd_mag};
            done_in  = 1'b1;
            state_in = F_IDLE;
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         cnt_ff   <= 3'd0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff   <= res_in;
      sign_ff  <= sign_in;
      exp_ff   <= exp_in;
      s_ff     <= s_in;
      sa_ff    <= sa_in;
      st_ff    <= st_in;
      sub_ff   <= sub_in;
      subn_ff  <= subn_in;
      shamt_ff <= shamt_in;
      ma_ff    <= ma_in;
      mb_ff    <= mb_in;
   end

   assign fpu_rsp.done   = done_ff;
   assign fpu_rsp.result = res_ff;

endmodule

@@ sv/cubic_inverse_by_bisection.sv @@
// Top level of the cubic inverse block: bisection sequencer around a shared binary64 unit.
//
// The block takes a target pressure word (an IEEE double) and answers one word with the
// signed 32-bit converter code x whose calibration value A*x^3 + B*x^2 + C*x + D comes
// within 0.5 of the target, and a found flag. The non-negative code range is tried first,
// then the negative one; a range whose end values do not bracket the target is skipped,
// and when neither brackets it the answer is code 0 with found low. Inside a range the
// midpoint is bisected, rounded half away from zero, until the tolerance is met or after
// MAX_STEPS steps. The four coefficients are written as double bit patterns over the csr
// port, one index per coefficient; the user must write them only while the block is
// idle, as the block itself does not enforce it. All arithmetic goes through a single
// multi-cycle floating-point unit, and it sets the rate. A result that goes subnormal
// passes through an extra denormalising step, and an operand that is zero, infinite or
// NaN is answered straight from the unit's idle state. One cubic evaluation is ten
// floating-point operations, and a bisection step is an evaluation plus a subtraction.
// The block accepts a new word only when idle, and a finished result waits in the
// output register without holding up the next word.
module cubic_inverse_by_bisection #(
   parameter int MAX_STEPS = cib_pkg::MAX_STEPS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   cib_req_if.sink                        req_ch,
   cib_rsp_if.source                      rsp_ch,
   input  logic                           csr_we,
   input  logic [cib_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [cib_pkg::DBL_W-1:0]      csr_wdata
);
   import cib_pkg::*;

   localparam int StepW = $clog2(MAX_STEPS + 1);

   localparam logic signed [CODE_W-1:0] CODE_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [CODE_W-1:0] CODE_MIN = 32'sh8000_0000;
   localparam logic [62:0]              HALF_MAG = 63'h3FE0_0000_0000_0000;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_RANGE = 3'd1;
   localparam logic [2:0] S_GO    = 3'd2;
   localparam logic [2:0] S_WAIT  = 3'd3;
   localparam logic [2:0] S_EDONE = 3'd4;
   localparam logic [2:0] S_OUT   = 3'd5;

   localparam logic [1:0] PH_FL  = 2'd0;
   localparam logic [1:0] PH_FH  = 2'd1;
   localparam logic [1:0] PH_MID = 2'd2;

   // Operation sequence of one evaluation; the last one only runs for a midpoint.
   localparam logic [3:0] EV_CVT   = 4'd0;
   localparam logic [3:0] EV_AX    = 4'd1;
   localparam logic [3:0] EV_AXX   = 4'd2;
   localparam logic [3:0] EV_AXXX  = 4'd3;
   localparam logic [3:0] EV_BX    = 4'd4;
   localparam logic [3:0] EV_BXX   = 4'd5;
   localparam logic [3:0] EV_CX    = 4'd6;
   localparam logic [3:0] EV_SUM32 = 4'd7;
   localparam logic [3:0] EV_SUM1  = 4'd8;
   localparam logic [3:0] EV_SUMD  = 4'd9;
   localparam logic [3:0] EV_DIFF  = 4'd10;

   logic [2:0]              state_ff, state_in;
   logic [1:0]              phase_ff, phase_in;
   logic [3:0]              k_ff, k_in;
   logic                    rng_ff, rng_in;
   logic [StepW-1:0]        step_ff, step_in;
   logic                    rising_ff, rising_in;
   logic signed [CODE_W-1:0] left_ff, left_in, right_ff, right_in, x_ff, x_in;
   logic [DBL_W-1:0]        tgt_ff, tgt_in;
   logic [DBL_W-1:0]        ca_ff, cb_ff, cc_ff, cd_ff;
   logic [DBL_W-1:0]        xd_ff, xd_in, t3_ff, t3_in, t2_ff, t2_in, t1_ff, t1_in;
   logic [DBL_W-1:0]        s_ff, s_in, diff_ff, diff_in, fl_ff, fl_in;
   logic signed [CODE_W-1:0] res_code_ff, res_code_in;
   logic                    res_found_ff, res_found_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [CODE_W-1:0] rsp_code_ff, rsp_code_in;
   logic                    rsp_found_ff, rsp_found_in;

   fpu_req_type             fpu_req;
   fpu_rsp_type             fpu_rsp;

   logic [3:0]              last_k;
   logic [DBL_W-1:0]        mn, mx;
   logic                    bracket, go_left;
   logic signed [CODE_W-1:0] nl, nr;

   cib_fpu u_fpu (
      .clock   (clock),
      .reset   (reset),
      .fpu_req (fpu_req),
      .fpu_rsp (fpu_rsp)
   );

   always_comb begin
      fpu_req.start = state_ff == S_GO;
      fpu_req.op    = FOP_MUL;
      fpu_req.a     = t3_ff;
      fpu_req.b     = xd_ff;
      case (k_ff) inside
         EV_CVT:          begin fpu_req.op = FOP_CVT; fpu_req.a = {32'd0, x_ff}; end
         EV_AX:           fpu_req.a = ca_ff;
         EV_AXX, EV_AXXX: fpu_req.a = t3_ff;
         EV_BX:           fpu_req.a = cb_ff;
         EV_BXX:          fpu_req.a = t2_ff;
         EV_CX:           fpu_req.a = cc_ff;
         EV_SUM32:        begin fpu_req.op = FOP_ADD; fpu_req.a = t3_ff; fpu_req.b = t2_ff; end
         EV_SUM1:         begin fpu_req.op = FOP_ADD; fpu_req.a = s_ff; fpu_req.b = t1_ff; end
         EV_SUMD:         begin fpu_req.op = FOP_ADD; fpu_req.a = s_ff; fpu_req.b = cd_ff; end
         default: begin
            // Subtraction as an add of the negated target.
            fpu_req.op = FOP_ADD;
            fpu_req.a  = s_ff;
            fpu_req.b  = {~tgt_ff[63], tgt_ff[62:0]};
         end
      endcase
   end

   always_comb begin
      last_k  = (phase_ff == PH_MID) ? EV_DIFF : EV_SUMD;
      mn      = fp_lt(s_ff, fl_ff) ? s_ff : fl_ff;
      mx      = fp_lt(fl_ff, s_ff) ? s_ff : fl_ff;
      bracket = fp_le(mn, tgt_ff) && fp_le(tgt_ff, mx);
      go_left = rising_ff ? fp_lt(s_ff, tgt_ff) : fp_lt(tgt_ff, s_ff);
      nl      = go_left ? x_ff : left_ff;
      nr      = go_left ? right_ff : x_ff;

      state_in     = state_ff;
      phase_in     = phase_ff;
      k_in         = k_ff;
      rng_in       = rng_ff;
      step_in      = step_ff;
      rising_in    = rising_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      x_in         = x_ff;
      tgt_in       = tgt_ff;
      xd_in        = xd_ff;
      t3_in        = t3_ff;
      t2_in        = t2_ff;
      t1_in        = t1_ff;
      s_in         = s_ff;
      diff_in      = diff_ff;
      fl_in        = fl_ff;
      res_code_in  = res_code_ff;
      res_found_in = res_found_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_code_in  = rsp_code_ff;
      rsp_found_in = rsp_found_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               tgt_in   = req_ch.target_pressure;
               rng_in   = 1'b0;
               state_in = S_RANGE;
            end
         end
         S_RANGE: begin
            left_in  = rng_ff ? CODE_MIN : '0;
            right_in = rng_ff ? '0 : CODE_MAX;
            x_in     = rng_ff ? CODE_MIN : '0;
            phase_in = PH_FL;
            k_in     = EV_CVT;
            state_in = S_GO;
         end
         S_GO: state_in = S_WAIT;
         S_WAIT: begin
            if (fpu_rsp.done) begin
               case (k_ff) inside
                  EV_CVT:                  xd_in   = fpu_rsp.result;
                  EV_AX, EV_AXX, EV_AXXX:  t3_in   = fpu_rsp.result;
                  EV_BX, EV_BXX:           t2_in   = fpu_rsp.result;
                  EV_CX:                   t1_in   = fpu_rsp.result;
                  EV_SUM32, EV_SUM1, EV_SUMD: s_in = fpu_rsp.result;
                  default:                 diff_in = fpu_rsp.result;
               endcase
               if (k_ff == last_k) begin
                  state_in = S_EDONE;
               end else begin
                  k_in     = k_ff + 4'd1;
                  state_in = S_GO;
               end
            end
         end
         S_EDONE: begin
            k_in     = EV_CVT;
            state_in = S_GO;
            unique case (phase_ff)
               PH_FL: begin
                  fl_in    = s_ff;
                  x_in     = right_ff;
                  phase_in = PH_FH;
               end
               PH_FH: begin
                  if (bracket) begin
                     rising_in = fp_lt(fl_ff, s_ff);
                     step_in   = '0;
                     x_in      = mid_round(left_ff, right_ff);
                     phase_in  = PH_MID;
                  end else if (!rng_ff) begin
                     rng_in   = 1'b1;
                     state_in = S_RANGE;
                  end else begin
                     res_code_in  = '0;
                     res_found_in = 1'b0;
                     state_in     = S_OUT;
                  end
               end
               default: begin
                  if (diff_ff[62:0] < HALF_MAG) begin
                     // Within tolerance; a NaN difference never lands here.
                     res_code_in  = x_ff;
                     res_found_in = 1'b1;
                     state_in     = S_OUT;
                  end else begin
                     left_in  = nl;
                     right_in = nr;
                     if (step_ff == StepW'(MAX_STEPS - 1)) begin
                        res_code_in  = mid_round(nl, nr);
                        res_found_in = 1'b1;
                        state_in     = S_OUT;
                     end else begin
                        step_in = step_ff + StepW'(1);
                        x_in    = mid_round(nl, nr);
                     end
                  end
               end
            endcase
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_code_in  = res_code_ff;
               rsp_found_in = res_found_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_FL;
         k_ff         <= EV_CVT;
         rng_ff       <= 1'b0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         ca_ff        <= '0;
         cb_ff        <= '0;
         cc_ff        <= '0;
         cd_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         k_ff         <= k_in;
         rng_ff       <= rng_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_COEF_CUBIC:  ca_ff <= csr_wdata;
               CSR_COEF_SQUARE: cb_ff <= csr_wdata;
               CSR_COEF_LINEAR: cc_ff <= csr_wdata;
               CSR_COEF_OFFSET: cd_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rising_ff    <= rising_in;
      left_ff      <= left_in;
      right_ff     <= right_in;
      x_ff         <= x_in;
      tgt_ff       <= tgt_in;
      xd_ff        <= xd_in;
      t3_ff        <= t3_in;
      t2_ff        <= t2_in;
      t1_ff        <= t1_in;
      s_ff         <= s_in;
      diff_ff      <= diff_in;
      fl_ff        <= fl_in;
      res_code_ff  <= res_code_in;
      res_found_ff <= res_found_in;
      rsp_code_ff  <= rsp_code_in;
      rsp_found_ff <= rsp_found_in;
   end

   assign req_ch.ready     = state_ff == S_IDLE;
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.conv_code = rsp_code_ff;
   assign rsp_ch.found     = rsp_found_ff;

   // The floating-point unit only answers an operation that the sequencer waits for.
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      fpu_rsp.done |-> state_ff == S_WAIT)
      else $error("floating-point result arrived outside the wait state");

   // A not-found answer is only possible after both ranges were tried.
   a_notfound_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && !res_found_ff) |-> rng_ff)
      else $error("not-found answer before the negative range was tried");

   // The bisection counter stays inside the step budget during a midpoint evaluation.
   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_MID && state_ff == S_EDONE) |-> step_ff < StepW'(MAX_STEPS))
      else $error("bisection step count past its limit");

   // An accepted word always starts with the non-negative range.
   a_start_range: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> (state_ff == S_RANGE && !rng_ff))
      else $error("search did not start on the non-negative range");

endmodule
